[sv/smx_pkg.sv]
// shared types and constants of the stack machine executor
package smx_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned PROD_W  = 2 * VALUE_W;
  localparam int unsigned OP_W    = 4;

  localparam logic signed [PROD_W-1:0] RES_MAX = PROD_W'(64'sd1000000000);
  localparam logic signed [PROD_W-1:0] RES_MIN = -RES_MAX;

  typedef enum logic [OP_W-1:0] {
    OP_START = 4'd0,
    OP_NUM   = 4'd1,
    OP_POP   = 4'd2,
    OP_INV   = 4'd3,
    OP_DUP   = 4'd4,
    OP_SWP   = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_MUL   = 4'd8,
    OP_DIV   = 4'd9,
    OP_MOD   = 4'd10,
    OP_END   = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EXEC,
    ST_DIV,
    ST_WB,
    ST_END_RD,
    ST_EMIT
  } state_e;

endpackage

[sv/smx_ram.sv]
// generic single write port ram with registered read
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/smx_div.sv]
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module smx_div
  import smx_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [VALUE_W-1:0] dividend_i,
  input  logic signed [VALUE_W-1:0] divisor_i,
  output logic                      done_o,
  output logic signed [VALUE_W:0]   quot_o,
  output logic signed [VALUE_W-1:0] rem_o
);

  localparam int unsigned STEP_W = $clog2(VALUE_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VALUE_W-1:0] quo_q, quo_d;
  logic [VALUE_W-1:0] dvs_q, dvs_d;
  logic               neg_q_q, neg_q_d;
  logic               neg_r_q, neg_r_d;
  logic [VALUE_W:0]   trial;
  logic               fits;

  assign trial = {rem_q, quo_q[VALUE_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_q_d = neg_q_q;
    neg_r_d = neg_r_q;
    if (start_i) begin
      busy_d  = 1'b1;
      step_d  = STEP_W'(VALUE_W - 1);
      rem_d   = '0;
      // magnitudes; the most negative value still fits unsigned
      quo_d   = dividend_i[VALUE_W-1] ? VALUE_W'(-dividend_i) : VALUE_W'(dividend_i);
      dvs_d   = divisor_i[VALUE_W-1] ? VALUE_W'(-divisor_i) : VALUE_W'(divisor_i);
      neg_q_d = dividend_i[VALUE_W-1] ^ divisor_i[VALUE_W-1];
      neg_r_d = dividend_i[VALUE_W-1];
    end else if (busy_q) begin
      rem_d = fits ? VALUE_W'(trial - {1'b0, dvs_q}) : trial[VALUE_W-1:0];
      quo_d = {quo_q[VALUE_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    dvs_q   <= dvs_d;
    neg_q_q <= neg_q_d;
    neg_r_q <= neg_r_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign rem_o  = neg_r_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

[sv/stack_machine_executor.sv]
// stack machine executor top level: sequencer, stack ram, alu and divider
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: value; tuser: op
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: result; tuser: error
//
// start, num and pop complete in idle; inv and dup pass through rd_a, exec and wb; swp, add, sub and mul also rd_b
// div and mod add the div state, which waits on the bit-serial divider
// end passes through end_rd and emit, and waits in emit for the output register to drain
// each operand is read through the single stack ram read port
// reset empties the stack and clears the error flag; the ram is not cleared
// a result waiting on m_axis stalls only a following end
module stack_machine_executor
  import smx_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] value
  input  logic [3:0]  s_axis_tuser,   // [3:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [30:0] result
  output logic        m_axis_tuser    // [0] error
);

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  state_e                    state_q, state_d;
  op_e                       op_q, op_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      err_q, err_d;
  logic signed [VALUE_W-1:0] a_q, a_d;
  logic signed [VALUE_W-1:0] b_q, b_d;
  logic signed [PROD_W-1:0]  res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]        out_data_q, out_data_d;
  logic                      out_err_q, out_err_d;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;

  logic                      div_start;
  logic                      div_done;
  logic signed [VALUE_W:0]   div_quot;
  logic signed [VALUE_W-1:0] div_rem;

  op_e                       in_op;
  logic signed [VALUE_W-1:0] in_val;
  logic                      in_fire;
  logic [ADDR_W-1:0]         top_addr;
  logic [ADDR_W-1:0]         sec_addr;
  logic [ADDR_W-1:0]         push_addr;
  logic                      full;
  logic                      out_free;
  logic                      out_of_range;
  logic signed [PROD_W-1:0]  prod;

  assign in_op        = op_e'(s_axis_tuser);
  assign in_val       = $signed(s_axis_tdata[VALUE_W-1:0]);
  assign in_fire      = s_axis_tvalid && s_axis_tready;
  assign top_addr     = ADDR_W'(cnt_q - CNT_W'(1));
  assign sec_addr     = ADDR_W'(cnt_q - CNT_W'(2));
  assign push_addr    = ADDR_W'(cnt_q);
  assign full         = cnt_q == CNT_W'(STACK_DEPTH);
  assign out_free     = !out_valid_q || m_axis_tready;
  assign out_of_range = (res_q > RES_MAX) || (res_q < RES_MIN);
  assign prod         = b_q * a_q;

  smx_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (b_q),
    .divisor_i  (a_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_END: state_d = ST_END_RD;
            OP_INV, OP_DUP: begin
              if (!err_q && cnt_q != '0) state_d = ST_RD_A;
            end
            OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (!err_q && cnt_q >= CNT_W'(2)) state_d = ST_RD_A;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_A: begin
        state_d = (op_q == OP_INV || op_q == OP_DUP) ? ST_EXEC : ST_RD_B;
      end
      ST_RD_B: state_d = ST_EXEC;
      ST_EXEC: begin
        if (op_q == OP_DIV || op_q == OP_MOD) begin
          state_d = (a_q == '0) ? ST_IDLE : ST_DIV;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_WB;
      end
      ST_WB:     state_d = ST_IDLE;
      ST_END_RD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d        = op_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    a_d         = a_q;
    b_d         = b_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_err_d   = out_err_q;
    ram_we      = 1'b0;
    ram_waddr   = push_addr;
    ram_wdata   = '0;
    ram_raddr   = top_addr;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d = in_op;
          case (in_op)
            OP_START: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_val;
              cnt_d     = CNT_W'(1);
              err_d     = 1'b0;
            end
            OP_NUM: begin
              if (!err_q) begin
                if (full) begin
                  err_d = 1'b1;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = in_val;
                  cnt_d     = cnt_q + 1'b1;
                end
              end
            end
            OP_POP: begin
              if (!err_q) begin
                if (cnt_q == '0) err_d = 1'b1;
                else cnt_d = cnt_q - 1'b1;
              end
            end
            OP_INV, OP_DUP: begin
              if (!err_q && cnt_q == '0) err_d = 1'b1;
            end
            OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (!err_q && cnt_q < CNT_W'(2)) err_d = 1'b1;
            end
            OP_END: ram_raddr = '0;
            default: op_d = in_op;
          endcase
        end
      end
      ST_RD_A: begin
        a_d       = $signed(ram_rdata);
        ram_raddr = sec_addr;
      end
      ST_RD_B: b_d = $signed(ram_rdata);
      ST_EXEC: begin
        case (op_q)
          OP_INV: res_d = -PROD_W'(a_q);
          OP_DUP: res_d = PROD_W'(a_q);
          OP_SWP: begin
            // old top goes one down now, old second lands on top in write-back
            ram_we    = 1'b1;
            ram_waddr = sec_addr;
            ram_wdata = a_q;
            res_d     = PROD_W'(b_q);
          end
          OP_ADD: res_d = PROD_W'(b_q) + PROD_W'(a_q);
          OP_SUB: res_d = PROD_W'(b_q) - PROD_W'(a_q);
          OP_MUL: res_d = prod;
          OP_DIV, OP_MOD: begin
            if (a_q == '0) err_d = 1'b1;
            else div_start = 1'b1;
          end
          default: res_d = res_q;
        endcase
      end
      ST_DIV: begin
        if (div_done) begin
          res_d = (op_q == OP_DIV) ? PROD_W'(div_quot) : PROD_W'(div_rem);
        end
      end
      ST_WB: begin
        case (op_q)
          OP_SWP: begin
            ram_we    = 1'b1;
            ram_waddr = top_addr;
            ram_wdata = res_q[VALUE_W-1:0];
          end
          OP_DUP: begin
            if (full) begin
              err_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = res_q[VALUE_W-1:0];
              cnt_d     = cnt_q + 1'b1;
            end
          end
          OP_INV: begin
            if (out_of_range) begin
              err_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = top_addr;
              ram_wdata = res_q[VALUE_W-1:0];
            end
          end
          default: begin
            // two operands in, one result out
            if (out_of_range) begin
              err_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = sec_addr;
              ram_wdata = res_q[VALUE_W-1:0];
              cnt_d     = cnt_q - 1'b1;
            end
          end
        endcase
      end
      ST_END_RD: a_d = $signed(ram_rdata);
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q || (cnt_q != CNT_W'(1));
          out_data_d  = (err_q || (cnt_q != CNT_W'(1))) ? '0 : a_q;
          cnt_d       = '0;
          err_d       = 1'b0;
        end
      end
      default: op_d = op_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    a_q        <= a_d;
    b_q        <= b_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
    out_err_q  <= out_err_d;
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};
  assign m_axis_tuser  = out_err_q;

endmodule
